// ===== rtl/rpt_pkg.sv =====
// ----------------------------------------------------------------------------
// rpt_pkg: shared types and constants of the rigid point transform
// Coordinate and trig widths, the wide internal coordinate type, register
// indexes, mode codes and the control struct that travels along the pipe.
// ----------------------------------------------------------------------------
`default_nettype none

package rpt_pkg;

    localparam int COORD_W  = 21;                 // Q10.10 coordinate
    localparam int TRIG_W   = 18;                 // Q1.16 cosine and sine
    localparam int FRAC_W   = 16;                 // fraction bits of the trig values
    localparam int ROT_W    = 2 * TRIG_W;         // packed cosine and sine
    localparam int XYZ_W    = 3 * COORD_W;        // packed centre or shift
    localparam int WIDE_W   = 29;                 // grows by two bits per axis, never wraps
    localparam int PROD_W   = TRIG_W + WIDE_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int POST_W   = WIDE_W + 1;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [WIDE_W-1:0]  t_wide;

    typedef struct packed {
        logic valid;
        logic last;
    } t_beat_ctl;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_Z  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 3'd5;

    localparam logic [1:0] MODE_FULL   = 2'd0;
    localparam logic [1:0] MODE_SHIFT  = 2'd1;
    localparam logic [1:0] MODE_ROTATE = 2'd2;

    localparam logic signed [SUM_W-1:0]  ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [POST_W-1:0] SAT_MAX    = POST_W'((1 << (COORD_W - 1)) - 1);
    localparam logic signed [POST_W-1:0] SAT_MIN    = -POST_W'(1 << (COORD_W - 1));

endpackage

`default_nettype wire

// ===== rtl/rpt_pre.sv =====
// ----------------------------------------------------------------------------
// rpt_pre: entry stage
// Widens the incoming point and removes the rotation centre when the mode
// asks for it. One register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rpt_pre (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_sub_centre,
    input  wire logic [rpt_pkg::XYZ_W-1:0]  i_centre,
    input  wire rpt_pkg::t_beat_ctl         i_ctl,
    input  wire rpt_pkg::t_coord            i_x,
    input  wire rpt_pkg::t_coord            i_y,
    input  wire rpt_pkg::t_coord            i_z,
    output rpt_pkg::t_beat_ctl              o_ctl,
    output rpt_pkg::t_wide                  o_x,
    output rpt_pkg::t_wide                  o_y,
    output rpt_pkg::t_wide                  o_z
);

    localparam int CW  = rpt_pkg::COORD_W;
    localparam int EXT = rpt_pkg::WIDE_W - rpt_pkg::COORD_W;

    rpt_pkg::t_beat_ctl r_ctl;
    rpt_pkg::t_wide     r_x, r_y, r_z;
    rpt_pkg::t_wide     w_cx, w_cy, w_cz;

    always_comb begin
        if (i_sub_centre) begin
            w_cx = {{EXT{i_centre[3*CW-1]}}, i_centre[3*CW-1:2*CW]};
            w_cy = {{EXT{i_centre[2*CW-1]}}, i_centre[2*CW-1:CW]};
            w_cz = {{EXT{i_centre[CW-1]}},   i_centre[CW-1:0]};
        end else begin
            w_cx = '0;
            w_cy = '0;
            w_cz = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= {{EXT{i_x[CW-1]}}, i_x} - w_cx;
            r_y <= {{EXT{i_y[CW-1]}}, i_y} - w_cy;
            r_z <= {{EXT{i_z[CW-1]}}, i_z} - w_cz;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

`default_nettype wire

// ===== rtl/rpt_rot_cell.sv =====
// ----------------------------------------------------------------------------
// rpt_rot_cell: one plane rotation cell
// Rotates the pair (a, b) by one cosine and sine pair and carries the third
// coordinate along. Products are registered, then summed and rounded.
// ----------------------------------------------------------------------------
`default_nettype none

module rpt_rot_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_bypass,
    input  wire logic [rpt_pkg::ROT_W-1:0]  i_rot,
    input  wire rpt_pkg::t_beat_ctl         i_ctl,
    input  wire rpt_pkg::t_wide             i_a,
    input  wire rpt_pkg::t_wide             i_b,
    input  wire rpt_pkg::t_wide             i_c,
    output rpt_pkg::t_beat_ctl              o_ctl,
    output rpt_pkg::t_wide                  o_a,
    output rpt_pkg::t_wide                  o_b,
    output rpt_pkg::t_wide                  o_c
);

    localparam int TW = rpt_pkg::TRIG_W;
    localparam int FW = rpt_pkg::FRAC_W;
    localparam int WW = rpt_pkg::WIDE_W;

    logic signed [TW-1:0]                 w_cos, w_sin;
    logic signed [rpt_pkg::PROD_W-1:0]    w_ca, w_sb, w_cb, w_sa;
    logic signed [rpt_pkg::PROD_W-1:0]    r_ca, r_sb, r_cb, r_sa;
    logic signed [rpt_pkg::SUM_W-1:0]     w_sum_a, w_sum_b;
    rpt_pkg::t_wide                       r_a, r_b, r_c1;
    logic                                 r_byp;
    rpt_pkg::t_beat_ctl                   r_ctl1, r_ctl2;
    rpt_pkg::t_wide                       r_oa, r_ob, r_oc;

    assign w_cos = i_rot[2*TW-1:TW];
    assign w_sin = i_rot[TW-1:0];

    assign w_ca = w_cos * i_a;
    assign w_sb = w_sin * i_b;
    assign w_cb = w_cos * i_b;
    assign w_sa = w_sin * i_a;

    // Round half up: add one half of the last kept bit, then floor.
    assign w_sum_a = rpt_pkg::SUM_W'(r_ca) - rpt_pkg::SUM_W'(r_sb) + rpt_pkg::ROUND_HALF;
    assign w_sum_b = rpt_pkg::SUM_W'(r_cb) + rpt_pkg::SUM_W'(r_sa) + rpt_pkg::ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ca  <= w_ca;
            r_sb  <= w_sb;
            r_cb  <= w_cb;
            r_sa  <= w_sa;
            r_a   <= i_a;
            r_b   <= i_b;
            r_c1  <= i_c;
            r_byp <= i_bypass;
            r_oc  <= r_c1;
            if (r_byp) begin
                r_oa <= r_a;
                r_ob <= r_b;
            end else begin
                r_oa <= w_sum_a[FW+WW-1:FW];
                r_ob <= w_sum_b[FW+WW-1:FW];
            end
        end
    end

    assign o_ctl = r_ctl2;
    assign o_a   = r_oa;
    assign o_b   = r_ob;
    assign o_c   = r_oc;

endmodule

`default_nettype wire

// ===== rtl/rpt_post.sv =====
// ----------------------------------------------------------------------------
// rpt_post: exit stage
// Adds the translation when the mode asks for it, saturates each coordinate
// to Q10.10 and holds the result beat in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpt_post (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_add_shift,
    input  wire logic [rpt_pkg::XYZ_W-1:0]  i_shift,
    input  wire rpt_pkg::t_beat_ctl         i_ctl,
    input  wire rpt_pkg::t_wide             i_x,
    input  wire rpt_pkg::t_wide             i_y,
    input  wire rpt_pkg::t_wide             i_z,
    output rpt_pkg::t_beat_ctl              o_ctl,
    output rpt_pkg::t_coord                 o_x,
    output rpt_pkg::t_coord                 o_y,
    output rpt_pkg::t_coord                 o_z
);

    localparam int CW  = rpt_pkg::COORD_W;
    localparam int PW  = rpt_pkg::POST_W;
    localparam int EXT = rpt_pkg::POST_W - rpt_pkg::COORD_W;

    logic signed [PW-1:0] w_sx, w_sy, w_sz;
    logic signed [PW-1:0] w_tx, w_ty, w_tz;
    rpt_pkg::t_beat_ctl   r_ctl;
    rpt_pkg::t_coord      r_x, r_y, r_z;

    function automatic rpt_pkg::t_coord sat(input logic signed [rpt_pkg::POST_W-1:0] v);
        rpt_pkg::t_coord res;
        if (v > rpt_pkg::SAT_MAX) begin
            res = rpt_pkg::SAT_MAX[rpt_pkg::COORD_W-1:0];
        end else if (v < rpt_pkg::SAT_MIN) begin
            res = rpt_pkg::SAT_MIN[rpt_pkg::COORD_W-1:0];
        end else begin
            res = v[rpt_pkg::COORD_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        if (i_add_shift) begin
            w_sx = {{EXT{i_shift[3*CW-1]}}, i_shift[3*CW-1:2*CW]};
            w_sy = {{EXT{i_shift[2*CW-1]}}, i_shift[2*CW-1:CW]};
            w_sz = {{EXT{i_shift[CW-1]}},   i_shift[CW-1:0]};
        end else begin
            w_sx = '0;
            w_sy = '0;
            w_sz = '0;
        end
        w_tx = PW'(i_x) + w_sx;
        w_ty = PW'(i_y) + w_sy;
        w_tz = PW'(i_z) + w_sz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= sat(w_tx);
            r_y <= sat(w_ty);
            r_z <= sat(w_tz);
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

`default_nettype wire

// ===== rtl/rigid_point_transform_core.sv =====
// ----------------------------------------------------------------------------
// rigid_point_transform_core: streaming rigid transform of Q10.10 points
// Each input beat carries one point or normal and gives exactly one result
// beat. In full mode the centre is removed, the point is rotated about x,
// then y, then z, and the translation is added; translate mode only adds the
// translation; rotate mode only rotates. Results saturate to Q10.10 and the
// last marker travels unchanged with its point.
//
// Channels: the input beat is taken when i_valid is high and o_stall is low,
// the result beat leaves when o_valid is high and i_stall is low. The user
// must write registers through i_cfg_we, i_cfg_index and i_cfg_data while
// no beat is in flight; the block itself does not enforce this.
// The pipe has one entry stage, three rotation cells of two stages each
// (products, then sum and round), and one exit stage that is also the
// output register. One beat is taken every cycle unless the pipe stalls.
// Reset is synchronous: it empties the pipe and clears the config registers to zero.
// When the receiver stalls a held result, the whole pipe freezes and o_stall
// rises, so no beat is lost; beats keep flowing into bubbles otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module rigid_point_transform_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [rpt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rpt_pkg::XYZ_W-1:0]      i_cfg_data,
    // input channel
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire rpt_pkg::t_coord                i_in_x,
    input  wire rpt_pkg::t_coord                i_in_y,
    input  wire rpt_pkg::t_coord                i_in_z,
    input  wire logic                           i_in_last,
    // output channel
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output rpt_pkg::t_coord                     o_out_x,
    output rpt_pkg::t_coord                     o_out_y,
    output rpt_pkg::t_coord                     o_out_z,
    output logic                                o_out_last
);

    // Config registers; the user must keep them stable while beats are in flight.
    logic [1:0]                  r_mode;
    logic [rpt_pkg::ROT_W-1:0]   r_rot_x, r_rot_y, r_rot_z;
    logic [rpt_pkg::XYZ_W-1:0]   r_centre, r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= '0;
            r_rot_x  <= '0;
            r_rot_y  <= '0;
            r_rot_z  <= '0;
            r_centre <= '0;
            r_shift  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rpt_pkg::CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                rpt_pkg::CFG_ROT_X:  r_rot_x  <= i_cfg_data[rpt_pkg::ROT_W-1:0];
                rpt_pkg::CFG_ROT_Y:  r_rot_y  <= i_cfg_data[rpt_pkg::ROT_W-1:0];
                rpt_pkg::CFG_ROT_Z:  r_rot_z  <= i_cfg_data[rpt_pkg::ROT_W-1:0];
                rpt_pkg::CFG_CENTRE: r_centre <= i_cfg_data;
                rpt_pkg::CFG_SHIFT:  r_shift  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Mode decode. The unused mode code behaves as the full transform.
    logic w_translate_only, w_rotate_only;
    assign w_translate_only = (r_mode == rpt_pkg::MODE_SHIFT);
    assign w_rotate_only    = (r_mode == rpt_pkg::MODE_ROTATE);

    // The pipe advances unless a finished result is held by the receiver.
    logic w_en;
    rpt_pkg::t_beat_ctl w_in_ctl, w_pre_ctl, w_cx_ctl, w_cy_ctl, w_cz_ctl, w_out_ctl;

    assign w_en     = !(w_out_ctl.valid && i_stall);
    assign o_stall  = !w_en;
    assign w_in_ctl = '{valid: i_valid, last: i_in_last};

    rpt_pkg::t_wide w_pre_x, w_pre_y, w_pre_z;
    rpt_pkg::t_wide w_rx_y, w_rx_z, w_rx_x;   // after the x-axis cell
    rpt_pkg::t_wide w_ry_z, w_ry_x, w_ry_y;   // after the y-axis cell
    rpt_pkg::t_wide w_rz_x, w_rz_y, w_rz_z;   // after the z-axis cell

    rpt_pre u_pre (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_sub_centre (!w_translate_only && !w_rotate_only),
        .i_centre     (r_centre),
        .i_ctl        (w_in_ctl),
        .i_x          (i_in_x),
        .i_y          (i_in_y),
        .i_z          (i_in_z),
        .o_ctl        (w_pre_ctl),
        .o_x          (w_pre_x),
        .o_y          (w_pre_y),
        .o_z          (w_pre_z)
    );

    // Rotation about x turns the (y, z) pair.
    rpt_rot_cell u_cell_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_bypass (w_translate_only),
        .i_rot    (r_rot_x),
        .i_ctl    (w_pre_ctl),
        .i_a      (w_pre_y),
        .i_b      (w_pre_z),
        .i_c      (w_pre_x),
        .o_ctl    (w_cx_ctl),
        .o_a      (w_rx_y),
        .o_b      (w_rx_z),
        .o_c      (w_rx_x)
    );

    // Rotation about y turns the (z, x) pair.
    rpt_rot_cell u_cell_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_bypass (w_translate_only),
        .i_rot    (r_rot_y),
        .i_ctl    (w_cx_ctl),
        .i_a      (w_rx_z),
        .i_b      (w_rx_x),
        .i_c      (w_rx_y),
        .o_ctl    (w_cy_ctl),
        .o_a      (w_ry_z),
        .o_b      (w_ry_x),
        .o_c      (w_ry_y)
    );

    // Rotation about z turns the (x, y) pair.
    rpt_rot_cell u_cell_z (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_bypass (w_translate_only),
        .i_rot    (r_rot_z),
        .i_ctl    (w_cy_ctl),
        .i_a      (w_ry_x),
        .i_b      (w_ry_y),
        .i_c      (w_ry_z),
        .o_ctl    (w_cz_ctl),
        .o_a      (w_rz_x),
        .o_b      (w_rz_y),
        .o_c      (w_rz_z)
    );

    rpt_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_add_shift (!w_rotate_only),
        .i_shift     (r_shift),
        .i_ctl       (w_cz_ctl),
        .i_x         (w_rz_x),
        .i_y         (w_rz_y),
        .i_z         (w_rz_z),
        .o_ctl       (w_out_ctl),
        .o_x         (o_out_x),
        .o_y         (o_out_y),
        .o_z         (o_out_z)
    );

    assign o_valid    = w_out_ctl.valid;
    assign o_out_last = w_out_ctl.last;

endmodule

`default_nettype wire
